[design/bpc_pkg.sv]
// Package for the barometer compensation block: field widths, register
// indexes, fixed constants of the compensation formulas and the divider sideband type.
// Used by the interfaces, the divider pipeline and the top level.
package bpc_pkg;

    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 21;
    localparam int PRESS_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C  = 2'd3;

    // Quotient and divisor widths of the pressure division.
    localparam int DIV_QUO_W = 64;
    localparam int DIV_DEN_W = 31;

    localparam int          TF_OFFSET  = 128000;
    localparam int          T_ROUND    = 128;
    localparam int          P4_SHIFT   = 35;
    localparam logic [20:0] RAW_FULL   = 21'd1048576;
    localparam logic [63:0] V1_BIAS    = 64'd1 << 47;
    localparam logic [63:0] NUM_SCALE  = 64'd3125;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              zero;
        logic              neg;
    } bpc_side_t;

endpackage

[design/bpc_ifs.sv]
// Handshake interfaces for the barometer compensation block: the sample
// channel in and the result channel out. Depends on bpc_pkg.
interface bpc_sample_if
    import bpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_result_if
    import bpc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic [PRESS_W-1:0]        pressure_q24_8;
    logic                      pressure_valid;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output pressure_valid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input pressure_valid, output ready);
endinterface

[design/bpc_div_pipe.sv]
// Pipelined radix-2 restoring divider, one quotient bit per stage, for the
// pressure division of unsigned magnitudes. Depends on bpc_pkg.
module bpc_div_pipe
    import bpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DIV_QUO_W-1:0] in_num,
    input  logic [DIV_DEN_W-1:0] in_den,
    input  bpc_side_t            in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIV_QUO_W-1:0] out_quo,
    output bpc_side_t            out_side
);

    localparam int N = DIV_QUO_W;

    logic [N-1:0]           vld_reg;
    logic [N-1:0]           en;
    logic [DIV_DEN_W-1:0]   rem_reg  [N];
    logic [DIV_QUO_W-1:0]   dq_reg   [N];
    logic [DIV_DEN_W-1:0]   den_reg  [N];
    bpc_side_t              side_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                 vld_in;
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_QUO_W-1:0] dq_in;
        logic [DIV_DEN_W-1:0] den_in;
        bpc_side_t            side_in;
        logic [DIV_DEN_W:0]   trial;
        logic                 fits;
        logic [DIV_DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign dq_in   = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign dq_in   = dq_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // A stage may load when it is empty or some later stage has room.
        assign en[k]    = out_ready || !(&vld_reg[N-1:k]);
        assign trial    = {rem_in, dq_in[N-1]};
        assign fits     = trial >= {1'b0, den_in};
        assign rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next;
                dq_reg[k]   <= {dq_in[N-2:0], fits};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N-1];
    assign out_quo   = dq_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

[design/baro_pressure_temp_compensation.sv]
// Barometer compensation, integer scheme. Each sample item carries a raw
// 20-bit temperature and a raw 20-bit pressure; each result item gives the
// temperature in hundredths of a degree, the pressure in pascal as unsigned
// Q24.8 saturated to 32 bits, and a flag that is low when the divisor of the
// pressure formula is zero (the pressure field then reads 0). The block is a
// fully pipelined datapath: it takes one item every clock cycle unless a
// stalled result has filled the pipeline, and it is made of nine front stages,
// the 64-stage radix-2 divider (one quotient bit per stage) and six back
// stages, the last of which is the output register. Every stage loads
// whenever it or a later stage has room, so a stalled result does not stop
// new items until the pipeline is full. The calibration words are written
// through the plain write port and must only be changed while no item is in
// flight. Depends on bpc_pkg, bpc_ifs and bpc_div_pipe.
module baro_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bpc_sample_if.sink            sample,
    bpc_result_if.source          result
);

    localparam int F_N = 9;
    localparam int P_N = 6;

    // Calibration registers.
    logic [47:0] temp_cal_reg;
    logic [63:0] pcal_a_reg;
    logic [63:0] pcal_b_reg;
    logic [15:0] pcal_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg <= '0;
            pcal_a_reg   <= '0;
            pcal_b_reg   <= '0;
            pcal_c_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP_CAL: temp_cal_reg <= cfg_data[47:0];
                CFG_PRESS_A:  pcal_a_reg   <= cfg_data;
                CFG_PRESS_B:  pcal_b_reg   <= cfg_data;
                CFG_PRESS_C:  pcal_c_reg   <= cfg_data[15:0];
                default:      pcal_c_reg   <= pcal_c_reg;
            endcase
        end
    end

    // Coefficients: T1 and P1 are unsigned, all others signed.
    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_cal_reg[15:0];
    assign t2 = $signed(temp_cal_reg[31:16]);
    assign t3 = $signed(temp_cal_reg[47:32]);
    assign p1 = pcal_a_reg[15:0];
    assign p2 = $signed(pcal_a_reg[31:16]);
    assign p3 = $signed(pcal_a_reg[47:32]);
    assign p4 = $signed(pcal_a_reg[63:48]);
    assign p5 = $signed(pcal_b_reg[15:0]);
    assign p6 = $signed(pcal_b_reg[31:16]);
    assign p7 = $signed(pcal_b_reg[47:32]);
    assign p8 = $signed(pcal_b_reg[63:48]);
    assign p9 = $signed(pcal_c_reg);

    // Stage control. Stage k loads when it is empty or a later stage has room.
    logic [F_N-1:0] f_vld_reg;
    logic [F_N-1:0] en_f;
    logic [P_N-1:0] p_vld_reg;
    logic [P_N-1:0] en_p;
    logic           div_in_ready;
    logic           div_out_valid;

    for (genvar k = 0; k < F_N; k++) begin : g_en_f
        assign en_f[k] = div_in_ready || !(&f_vld_reg[F_N-1:k]);
    end
    for (genvar k = 0; k < P_N; k++) begin : g_en_p
        assign en_p[k] = result.ready || !(&p_vld_reg[P_N-1:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= '0;
            p_vld_reg <= '0;
        end
        else
        begin
            if (en_f[0])
            begin
                f_vld_reg[0] <= sample.valid;
            end
            for (int k = 1; k < F_N; k++)
            begin
                if (en_f[k])
                begin
                    f_vld_reg[k] <= f_vld_reg[k-1];
                end
            end
            if (en_p[0])
            begin
                p_vld_reg[0] <= div_out_valid;
            end
            for (int k = 1; k < P_N; k++)
            begin
                if (en_p[k])
                begin
                    p_vld_reg[k] <= p_vld_reg[k-1];
                end
            end
        end
    end

    assign sample.ready = en_f[0];

    // Front stage 1: the two temperature products.
    logic signed [18:0] a_next;
    logic signed [34:0] at2_next;
    logic signed [16:0] d_next;
    logic signed [33:0] dd_next;
    logic signed [34:0] f1_at2_reg;
    logic signed [33:0] f1_dd_reg;
    logic [RAW_W-1:0]   f1_rp_reg;

    assign a_next   = $signed({2'b00, sample.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
    assign at2_next = a_next * t2;
    assign d_next   = $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign dd_next  = d_next * d_next;

    always_ff @(posedge clk)
    begin
        if (en_f[0])
        begin
            f1_at2_reg <= at2_next;
            f1_dd_reg  <= dd_next;
            f1_rp_reg  <= sample.raw_pressure;
        end
    end

    // Front stage 2: first term scaled, square term times T3.
    logic signed [37:0] ddt3_next;
    logic signed [23:0] f2_xt_reg;
    logic signed [37:0] f2_ddt3_reg;
    logic [RAW_W-1:0]   f2_rp_reg;

    assign ddt3_next = $signed(f1_dd_reg[33:12]) * t3;

    always_ff @(posedge clk)
    begin
        if (en_f[1])
        begin
            f2_xt_reg   <= f1_at2_reg[34:11];
            f2_ddt3_reg <= ddt3_next;
            f2_rp_reg   <= f1_rp_reg;
        end
    end

    // Front stage 3: fine temperature.
    logic signed [24:0] tf_next;
    logic signed [24:0] f3_tf_reg;
    logic [RAW_W-1:0]   f3_rp_reg;

    assign tf_next = 25'(f2_xt_reg) + 25'($signed(f2_ddt3_reg[37:14]));

    always_ff @(posedge clk)
    begin
        if (en_f[2])
        begin
            f3_tf_reg <= tf_next;
            f3_rp_reg <= f2_rp_reg;
        end
    end

    // Front stage 4: centi-degree result and the first pressure products.
    logic signed [25:0] xp_next;
    logic signed [51:0] xx_next;
    logic signed [41:0] xp5_next;
    logic signed [41:0] xp2_next;
    logic signed [28:0] tc_next;
    logic signed [51:0] f4_xx_reg;
    logic signed [41:0] f4_xp5_reg;
    logic signed [41:0] f4_xp2_reg;
    logic [TEMP_W-1:0]  f4_tc_reg;
    logic [RAW_W-1:0]   f4_rp_reg;

    assign xp_next  = 26'(f3_tf_reg) - 26'(TF_OFFSET);
    assign xx_next  = xp_next * xp_next;
    assign xp5_next = xp_next * p5;
    assign xp2_next = xp_next * p2;
    assign tc_next  = 29'(f3_tf_reg) * 29'sd5 + 29'(T_ROUND);

    always_ff @(posedge clk)
    begin
        if (en_f[3])
        begin
            f4_xx_reg  <= xx_next;
            f4_xp5_reg <= xp5_next;
            f4_xp2_reg <= xp2_next;
            f4_tc_reg  <= tc_next[28:8];
            f4_rp_reg  <= f3_rp_reg;
        end
    end

    // Front stage 5: the square term times P6 and P3, kept modulo 2^64.
    logic signed [67:0] xxp6_full;
    logic signed [67:0] xxp3_full;
    logic signed [63:0] f5_xxp6_reg;
    logic signed [63:0] f5_xxp3_reg;
    logic signed [41:0] f5_xp5_reg;
    logic signed [41:0] f5_xp2_reg;
    logic [TEMP_W-1:0]  f5_tc_reg;
    logic [RAW_W-1:0]   f5_rp_reg;

    assign xxp6_full = f4_xx_reg * p6;
    assign xxp3_full = f4_xx_reg * p3;

    always_ff @(posedge clk)
    begin
        if (en_f[4])
        begin
            f5_xxp6_reg <= xxp6_full[63:0];
            f5_xxp3_reg <= xxp3_full[63:0];
            f5_xp5_reg  <= f4_xp5_reg;
            f5_xp2_reg  <= f4_xp2_reg;
            f5_tc_reg   <= f4_tc_reg;
            f5_rp_reg   <= f4_rp_reg;
        end
    end

    // Front stage 6: offset sum and divisor sum before the P1 scaling.
    logic signed [63:0] y_next;
    logic signed [63:0] x1_next;
    logic signed [63:0] f6_y_reg;
    logic signed [63:0] f6_x1_reg;
    logic [TEMP_W-1:0]  f6_tc_reg;
    logic [RAW_W-1:0]   f6_rp_reg;

    assign y_next  = f5_xxp6_reg + (64'(f5_xp5_reg) <<< 17) + (64'(p4) <<< P4_SHIFT);
    assign x1_next = (f5_xxp3_reg >>> 8) + (64'(f5_xp2_reg) <<< 12);

    always_ff @(posedge clk)
    begin
        if (en_f[5])
        begin
            f6_y_reg  <= y_next;
            f6_x1_reg <= x1_next;
            f6_tc_reg <= f5_tc_reg;
            f6_rp_reg <= f5_rp_reg;
        end
    end

    // Front stage 7: divisor product with P1, numerator difference.
    logic [63:0]        v1_base;
    logic [79:0]        v1_full;
    logic [20:0]        pp;
    logic [63:0]        diff_next;
    logic [63:0]        f7_v1_reg;
    logic [63:0]        f7_diff_reg;
    logic [TEMP_W-1:0]  f7_tc_reg;

    assign v1_base   = f6_x1_reg + V1_BIAS;
    assign v1_full   = v1_base * p1;
    assign pp        = RAW_FULL - {1'b0, f6_rp_reg};
    assign diff_next = {12'b0, pp, 31'b0} - f6_y_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[6])
        begin
            f7_v1_reg   <= v1_full[63:0];
            f7_diff_reg <= diff_next;
            f7_tc_reg   <= f6_tc_reg;
        end
    end

    // Front stage 8: divisor and scaled numerator.
    logic [63:0]                 num_next;
    logic signed [DIV_DEN_W-1:0] f8_den_reg;
    logic [63:0]                 f8_num_reg;
    logic [TEMP_W-1:0]           f8_tc_reg;

    assign num_next = f7_diff_reg * NUM_SCALE;

    always_ff @(posedge clk)
    begin
        if (en_f[7])
        begin
            f8_den_reg <= f7_v1_reg[63:33];
            f8_num_reg <= num_next;
            f8_tc_reg  <= f7_tc_reg;
        end
    end

    // Front stage 9: magnitudes and quotient sign for the divider.
    logic [DIV_QUO_W-1:0] f9_mn_reg;
    logic [DIV_DEN_W-1:0] f9_md_reg;
    bpc_side_t            f9_side_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[8])
        begin
            f9_mn_reg        <= f8_num_reg[63] ? (64'd0 - f8_num_reg) : f8_num_reg;
            f9_md_reg        <= f8_den_reg[DIV_DEN_W-1] ? (DIV_DEN_W'(0) - f8_den_reg)
                                                        : f8_den_reg;
            f9_side_reg.temp <= f8_tc_reg;
            f9_side_reg.zero <= (f8_den_reg == '0);
            f9_side_reg.neg  <= f8_num_reg[63] ^ f8_den_reg[DIV_DEN_W-1];
        end
    end

    logic [DIV_QUO_W-1:0] div_quo;
    bpc_side_t            div_side;

    bpc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg[F_N-1]),
        .in_ready  (div_in_ready),
        .in_num    (f9_mn_reg),
        .in_den    (f9_md_reg),
        .in_side   (f9_side_reg),
        .out_valid (div_out_valid),
        .out_ready (en_p[0]),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // Back stage 1: signed quotient.
    logic signed [63:0] p1_p_reg;
    bpc_side_t          p1_side_reg;

    always_ff @(posedge clk)
    begin
        if (en_p[0])
        begin
            p1_p_reg    <= div_side.neg ? (64'd0 - div_quo) : div_quo;
            p1_side_reg <= div_side;
        end
    end

    // Back stage 2: partial products of the quotient square, and P8 term.
    logic signed [63:0] q13;
    logic [63:0]        ll_next;
    logic [31:0]        hl_next;
    logic signed [79:0] p8p_full;
    logic signed [63:0] p2_p_reg;
    logic [63:0]        p2_ll_reg;
    logic [31:0]        p2_hl_reg;
    logic signed [63:0] p2_p8p_reg;
    bpc_side_t          p2_side_reg;

    assign q13      = p1_p_reg >>> 13;
    assign ll_next  = q13[31:0] * q13[31:0];
    assign hl_next  = q13[63:32] * q13[31:0];
    assign p8p_full = p1_p_reg * p8;

    always_ff @(posedge clk)
    begin
        if (en_p[1])
        begin
            p2_p_reg    <= p1_p_reg;
            p2_ll_reg   <= ll_next;
            p2_hl_reg   <= hl_next;
            p2_p8p_reg  <= p8p_full[63:0];
            p2_side_reg <= p1_side_reg;
        end
    end

    // Back stage 3: quotient square modulo 2^64.
    logic [63:0]        p3_qq_reg;
    logic signed [63:0] p3_p_reg;
    logic signed [63:0] p3_p8p_reg;
    bpc_side_t          p3_side_reg;

    always_ff @(posedge clk)
    begin
        if (en_p[2])
        begin
            p3_qq_reg   <= p2_ll_reg + {p2_hl_reg[30:0], 33'b0};
            p3_p_reg    <= p2_p_reg;
            p3_p8p_reg  <= p2_p8p_reg;
            p3_side_reg <= p2_side_reg;
        end
    end

    // Back stage 4: P9 term.
    logic signed [79:0] p9qq_full;
    logic signed [63:0] p4_p9qq_reg;
    logic signed [63:0] p4_p_reg;
    logic signed [63:0] p4_p8p_reg;
    bpc_side_t          p4_side_reg;

    assign p9qq_full = $signed(p3_qq_reg) * p9;

    always_ff @(posedge clk)
    begin
        if (en_p[3])
        begin
            p4_p9qq_reg <= p9qq_full[63:0];
            p4_p_reg    <= p3_p_reg;
            p4_p8p_reg  <= p3_p8p_reg;
            p4_side_reg <= p3_side_reg;
        end
    end

    // Back stage 5: second-order correction sum.
    logic signed [63:0] p5_s_reg;
    bpc_side_t          p5_side_reg;

    always_ff @(posedge clk)
    begin
        if (en_p[4])
        begin
            p5_s_reg    <= p4_p_reg + (p4_p9qq_reg >>> 25) + (p4_p8p_reg >>> 19);
            p5_side_reg <= p4_side_reg;
        end
    end

    // Back stage 6 is the output register: P7 offset, clamp to 32 bits, and
    // the zero-divisor case forces the pressure to 0 and clears the flag.
    logic signed [63:0]   pr;
    logic [PRESS_W-1:0]   pr_sat;
    logic [TEMP_W-1:0]    out_temp_reg;
    logic [PRESS_W-1:0]   out_press_reg;
    logic                 out_pvalid_reg;

    assign pr = (p5_s_reg >>> 8) + (64'(p7) <<< 4);

    always_comb
    begin
        priority if (pr[63])
        begin
            pr_sat = '0;
        end
        else if (|pr[62:32])
        begin
            pr_sat = '1;
        end
        else
        begin
            pr_sat = pr[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_p[5])
        begin
            out_temp_reg   <= p5_side_reg.temp;
            out_press_reg  <= p5_side_reg.zero ? '0 : pr_sat;
            out_pvalid_reg <= !p5_side_reg.zero;
        end
    end

    assign result.valid             = p_vld_reg[P_N-1];
    assign result.temperature_centi = $signed(out_temp_reg);
    assign result.pressure_q24_8    = out_press_reg;
    assign result.pressure_valid    = out_pvalid_reg;

endmodule
